/* sv/lz3_pkg.sv */
// lz3_pkg: shared types, widths, state codes and the lanczos-3 weight rom
// no dependencies; imported by every other file of the upscaler except lz3_ram
package lz3_pkg;

  localparam int PHASE_BITS        = 6;
  localparam int WEIGHT_FRAC_BITS  = 14;
  localparam int TAPS              = 5;
  localparam int NPHASE            = 1 << PHASE_BITS;
  localparam int MAX_SRC_WIDTH_DEF = 1024;
  localparam int MAX_SRC_HEIGHT_DEF = 512;

  localparam int WW   = WEIGHT_FRAC_BITS + 3;
  localparam int WPW  = 2 * WW;
  localparam int PRW  = WPW + 9;
  localparam int SUMW = PRW + 5;
  localparam int WSW  = WPW + 5;
  localparam int NW   = 39;
  localparam int DW   = 13;
  localparam int FW   = 23;
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_CALC = 1'b1;

  localparam logic [1:0] CFG_SRC_W = 2'd0;
  localparam logic [1:0] CFG_SRC_H = 2'd1;
  localparam logic [1:0] CFG_DST_W = 2'd2;
  localparam logic [1:0] CFG_DST_H = 2'd3;

  typedef struct packed {
    logic        func;
    logic [9:0]  src_col;
    logic [8:0]  src_row;
    logic [7:0]  pixel_in;
    logic [11:0] dst_col;
    logic [10:0] dst_row;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  pixel_out;
    logic [11:0] out_col;
    logic [10:0] out_row;
  } out_item_t;

  typedef struct packed {
    logic                  func;
    logic [9:0]            ld_col;
    logic [8:0]            ld_row;
    logic [7:0]            ld_pix;
    logic [FW-1:0]         fx;
    logic [FW-1:0]         fy;
    logic [PHASE_BITS-1:0] phx;
    logic [PHASE_BITS-1:0] phy;
    logic [11:0]           col;
    logic [10:0]           row;
  } job_t;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_TAPS, B_DRAIN, B_QDIV} back_state_t;

  typedef logic signed [WW-1:0] weight_t;
  typedef weight_t [TAPS-1:0]   wrow_t;
  typedef wrow_t [NPHASE-1:0]   wrom_t;

  // unsigned long division by shift and subtract, used while building the rom
  function automatic longint unsigned div_u64(longint unsigned n, longint unsigned d);
    logic [64:0]     r;
    longint unsigned q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // sin(pi*num/den) in q30, den is one or three phase periods
  function automatic longint unsigned sin_pi(longint unsigned num_in, logic third);
    longint unsigned den, num, theta, t;
    longint          acc;
    den = third ? 64'(3 * NPHASE) : 64'(NPHASE);
    num = num_in;
    if (num > den) return 64'd0;
    if (2 * num > den) num = den - num;
    theta = third ? div_u64(num * PI_Q30, 64'(3 * NPHASE)) : (num * PI_Q30) >> PHASE_BITS;
    acc = longint'(theta);
    t = theta;
    for (int i = 1; i <= 8; i++) begin
      t = (t * theta) >> 30;
      t = (t * theta) >> 30;
      t = div_u64(t, 64'((2 * i) * (2 * i + 1)));
      if ((i & 1) != 0) acc = acc - longint'(t);
      else acc = acc + longint'(t);
    end
    return (acc < 0) ? 64'd0 : longint'(acc);
  endfunction

  function automatic weight_t lanczos_weight(longint unsigned a);
    longint unsigned s1, s2, p, pi2, x2, w;
    logic            neg;
    if (a == 0) return weight_t'(1 << WEIGHT_FRAC_BITS);
    if (a >= 64'(3 * NPHASE)) return '0;
    s1  = sin_pi(a & 64'(NPHASE - 1), 1'b0);
    neg = ((a >> PHASE_BITS) & 64'd1) != 0;
    s2  = sin_pi(a, 1'b1);
    p   = (s1 * s2) >> 30;
    pi2 = (PI_Q30 * PI_Q30) >> 30;
    x2  = (a * a * pi2) >> (2 * PHASE_BITS);
    if (x2 == 0) return '0;
    w = div_u64(((3 * p) << WEIGHT_FRAC_BITS) + (x2 >> 1), x2);
    return neg ? weight_t'(-longint'(w)) : weight_t'(w);
  endfunction

  function automatic wrom_t build_rom();
    wrom_t rom;
    int    k;
    for (int ph = 0; ph < NPHASE; ph++) begin
      for (int t = 0; t < TAPS; t++) begin
        k = ph - (t - 2) * NPHASE;
        rom[ph][t] = lanczos_weight(64'((k < 0) ? -k : k));
      end
    end
    return rom;
  endfunction

  localparam wrom_t WROM = build_rom();

endpackage

/* sv/lz3_ram.sv */
// lz3_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module lz3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata <= mem_r[raddr];
  end
endmodule

/* sv/lz3_div.sv */
// lz3_div: restoring divider for the source position, one quotient bit a cycle
// depends on lz3_pkg
module lz3_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [lz3_pkg::NW-1:0] dividend,
  input  logic [lz3_pkg::DW-1:0] divisor,
  output logic                 done,
  output logic [lz3_pkg::NW-1:0] quotient
);
  import lz3_pkg::*;

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   quo_r, quo_nxt;
  logic [DW-1:0]   rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            run_r, run_nxt, done_r, done_nxt;
  logic [DW:0]     rem_sh;
  logic            bit_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  always_comb begin
    rem_sh   = {rem_r, quo_r[NW-1]};
    bit_q    = rem_sh >= {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = CNTW'(NW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = bit_q ? DW'(rem_sh - {1'b0, dvs_r}) : DW'(rem_sh);
      quo_nxt = {quo_r[NW-2:0], bit_q};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

/* sv/lz3_fifo.sv */
// lz3_fifo: short job queue between the front and back ends
// depends on lz3_pkg
module lz3_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lz3_pkg::job_t push_data,
  input  logic          pop,
  output lz3_pkg::job_t head,
  output logic          full,
  output logic          not_empty
);
  import lz3_pkg::*;

  job_t             mem_r [QDEPTH];
  logic [QAW-1:0]   wp_r, rp_r;
  logic [QAW:0]     cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
    if (push) mem_r[wp_r] <= push_data;
  end

  assign head      = mem_r[rp_r];
  assign full      = cnt_r == (QAW+1)'(QDEPTH);
  assign not_empty = cnt_r != '0;
endmodule

/* sv/lz3_front.sv */
// lz3_front: takes items, passes load items on, maps compute coordinates to source positions
// depends on lz3_pkg, lz3_div
module lz3_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lz3_pkg::in_item_t in_data,
  input  logic [10:0]       sw,
  input  logic [9:0]        sh,
  input  logic [12:0]       dst_w,
  input  logic [11:0]       dst_h,
  output logic              push,
  output lz3_pkg::job_t     push_data,
  input  logic              full
);
  import lz3_pkg::*;

  front_state_t   state_r, state_nxt;
  job_t           job_r, job_nxt, ld_job;
  logic           acc, div_go, dx_done, dy_done;
  logic [NW-1:0]  nx, ny, qx, qy;
  logic [DW-1:0]  dvx, dvy;
  logic [22:0]    prod_x;
  logic [20:0]    prod_y;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= F_IDLE;
    else state_r <= state_nxt;
    job_r <= job_nxt;
  end

  assign busy   = (state_r != F_IDLE) || full;
  assign acc    = start && !busy;
  assign div_go = acc && (in_data.func == FUNC_CALC);

  assign prod_x = 23'(in_data.dst_col) * 23'(sw - 11'd1);
  assign prod_y = 21'(in_data.dst_row) * 21'(sh - 10'd1);

  always_comb begin
    if (dst_w < 13'd2 || sw == '0) begin
      nx  = '0;
      dvx = DW'(1);
    end else begin
      nx  = {prod_x, 16'b0};
      dvx = dst_w - 13'd1;
    end
    if (dst_h < 12'd2 || sh == '0) begin
      ny  = '0;
      dvy = DW'(1);
    end else begin
      ny  = NW'({prod_y, 16'b0});
      dvy = DW'(dst_h - 12'd1);
    end
  end

  lz3_div u_div_x (.clk, .rst_n, .start(div_go), .dividend(nx), .divisor(dvx),
                   .done(dx_done), .quotient(qx));
  lz3_div u_div_y (.clk, .rst_n, .start(div_go), .dividend(ny), .divisor(dvy),
                   .done(dy_done), .quotient(qy));

  always_comb begin
    ld_job        = '0;
    ld_job.func   = FUNC_LOAD;
    ld_job.ld_col = in_data.src_col;
    ld_job.ld_row = in_data.src_row;
    ld_job.ld_pix = in_data.pixel_in;
  end

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    push      = 1'b0;
    push_data = ld_job;
    unique case (state_r)
      F_IDLE: begin
        if (acc) begin
          if (in_data.func == FUNC_CALC) begin
            job_nxt      = '0;
            job_nxt.func = FUNC_CALC;
            job_nxt.col  = in_data.dst_col;
            job_nxt.row  = in_data.dst_row;
            state_nxt    = F_DIV;
          end else begin
            push = 1'b1;
          end
        end
      end
      F_DIV: begin
        if (dx_done && dy_done) begin
          job_nxt.fx  = qx[NW-1:16];
          job_nxt.fy  = qy[NW-1:16];
          job_nxt.phx = qx[15:16-PHASE_BITS];
          job_nxt.phy = qy[15:16-PHASE_BITS];
          state_nxt   = F_PUSH;
        end
      end
      F_PUSH: begin
        push_data = job_r;
        if (!full) begin
          push      = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end
endmodule

/* sv/lz3_back.sv */
// lz3_back: frame store writes, 5x5 weighted window sum and final quotient
// depends on lz3_pkg, lz3_ram
module lz3_back #(
  parameter int MAX_SRC_WIDTH  = lz3_pkg::MAX_SRC_WIDTH_DEF,
  parameter int MAX_SRC_HEIGHT = lz3_pkg::MAX_SRC_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lz3_pkg::job_t      job,
  input  logic               job_valid,
  output logic               job_pop,
  input  logic [10:0]        sw,
  input  logic [9:0]         sh,
  output logic               out_valid,
  output lz3_pkg::out_item_t out_data
);
  import lz3_pkg::*;

  localparam int CW    = $clog2(MAX_SRC_WIDTH);
  localparam int RW    = $clog2(MAX_SRC_HEIGHT);
  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  back_state_t state_r, state_nxt;
  job_t        job_r, job_nxt;
  logic [2:0]  tx_r, tx_nxt, ty_r, ty_nxt, qc_r, qc_nxt;
  logic        p1_r, p1_nxt, p2_r, p3_r;
  logic        s1_v_r, s1_v_nxt, s2_v_r, s3_v_r;
  weight_t     s1_wx_r, s1_wx_nxt, s1_wy_r, s1_wy_nxt;
  logic signed [WPW-1:0]  s2_w_r, s3_w_r;
  logic [7:0]             s2_pix_r;
  logic signed [PRW-1:0]  s3_prod_r;
  logic signed [SUMW-1:0] sum_r, sum_nxt;
  logic signed [WSW-1:0]  wsum_r, wsum_nxt;
  logic [SUMW-1:0]        rem_r, rem_nxt, dv_r, dv_nxt, sum_abs, wsum_abs;
  logic [7:0]             q_r, q_nxt;
  logic                   ov_r, ov_nxt;
  out_item_t              od_r, od_nxt;

  logic signed [24:0] trow, tcol;
  logic               tap_in, we, re, ld_ok, zero_res, cap, qbit;
  logic [31:0]        ld_col_x, ld_row_x;
  logic [AW-1:0]      waddr, raddr;
  logic [7:0]         rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      p1_r    <= 1'b0;
      p2_r    <= 1'b0;
      p3_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p1_r    <= p1_nxt;
      p2_r    <= p1_r;
      p3_r    <= p2_r;
      ov_r    <= ov_nxt;
    end
    job_r     <= job_nxt;
    tx_r      <= tx_nxt;
    ty_r      <= ty_nxt;
    qc_r      <= qc_nxt;
    s1_v_r    <= s1_v_nxt;
    s1_wx_r   <= s1_wx_nxt;
    s1_wy_r   <= s1_wy_nxt;
    s2_v_r    <= s1_v_r;
    s2_w_r    <= s1_wx_r * s1_wy_r;
    s2_pix_r  <= rdata;
    s3_v_r    <= s2_v_r;
    s3_w_r    <= s2_w_r;
    s3_prod_r <= $signed({1'b0, s2_pix_r}) * s2_w_r;
    sum_r     <= sum_nxt;
    wsum_r    <= wsum_nxt;
    rem_r     <= rem_nxt;
    dv_r      <= dv_nxt;
    q_r       <= q_nxt;
    od_r      <= od_nxt;
  end

  // tap position and frame bounds
  assign trow   = $signed({2'b0, job_r.fy}) + $signed({22'b0, ty_r}) - 25'sd2;
  assign tcol   = $signed({2'b0, job_r.fx}) + $signed({22'b0, tx_r}) - 25'sd2;
  assign tap_in = !trow[24] && (trow < $signed({15'b0, sh}))
               && !tcol[24] && (tcol < $signed({14'b0, sw}));
  assign raddr  = AW'(AW'(trow[RW-1:0]) * AW'(MAX_SRC_WIDTH)) + AW'(tcol[CW-1:0]);
  assign re     = (state_r == B_TAPS) && tap_in;

  assign ld_col_x = 32'(job.ld_col);
  assign ld_row_x = 32'(job.ld_row);
  assign ld_ok    = (ld_col_x < 32'(MAX_SRC_WIDTH)) && (ld_row_x < 32'(MAX_SRC_HEIGHT));
  assign waddr    = AW'(AW'(ld_row_x[RW-1:0]) * AW'(MAX_SRC_WIDTH)) + AW'(ld_col_x[CW-1:0]);
  assign we       = job_pop && (job.func == FUNC_LOAD) && ld_ok;

  lz3_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk, .we, .waddr, .wdata(job.ld_pix), .re, .raddr, .rdata
  );

  assign sum_abs  = sum_r[SUMW-1] ? SUMW'(-sum_r) : SUMW'(sum_r);
  assign wsum_abs = wsum_r[WSW-1] ? SUMW'(-wsum_r) : SUMW'(wsum_r);
  assign zero_res = (wsum_r == '0) || (sum_r[SUMW-1] != wsum_r[WSW-1]);
  assign cap      = sum_abs >= (wsum_abs << 8);
  assign qbit     = rem_r >= dv_r;

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    tx_nxt    = tx_r;
    ty_nxt    = ty_r;
    qc_nxt    = qc_r;
    p1_nxt    = 1'b0;
    s1_v_nxt  = 1'b0;
    s1_wx_nxt = $signed(WROM[job_r.phx][tx_r]);
    s1_wy_nxt = $signed(WROM[job_r.phy][ty_r]);
    sum_nxt   = sum_r;
    wsum_nxt  = wsum_r;
    rem_nxt   = rem_r;
    dv_nxt    = dv_r;
    q_nxt     = q_r;
    ov_nxt    = 1'b0;
    od_nxt    = od_r;
    job_pop   = 1'b0;

    if (p3_r && s3_v_r) begin
      sum_nxt  = sum_r + SUMW'(s3_prod_r);
      wsum_nxt = wsum_r + WSW'(s3_w_r);
    end

    unique case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          if (job.func == FUNC_CALC) begin
            job_nxt   = job;
            tx_nxt    = '0;
            ty_nxt    = '0;
            sum_nxt   = '0;
            wsum_nxt  = '0;
            state_nxt = B_TAPS;
          end
        end
      end
      B_TAPS: begin
        p1_nxt   = 1'b1;
        s1_v_nxt = tap_in;
        if (tx_r == 3'(TAPS - 1)) begin
          tx_nxt = '0;
          ty_nxt = ty_r + 3'd1;
          if (ty_r == 3'(TAPS - 1)) state_nxt = B_DRAIN;
        end else begin
          tx_nxt = tx_r + 3'd1;
        end
      end
      B_DRAIN: begin
        if (!p1_r && !p2_r && !p3_r) begin
          rem_nxt   = sum_abs;
          dv_nxt    = wsum_abs << 7;
          qc_nxt    = '0;
          q_nxt     = '0;
          state_nxt = B_QDIV;
        end
      end
      B_QDIV: begin
        if (qbit) rem_nxt = rem_r - dv_r;
        dv_nxt = dv_r >> 1;
        q_nxt  = {q_r[6:0], qbit};
        qc_nxt = qc_r + 3'd1;
        if (qc_r == 3'd7) begin
          ov_nxt           = 1'b1;
          od_nxt.pixel_out = zero_res ? 8'd0 : (cap ? 8'd255 : {q_r[6:0], qbit});
          od_nxt.out_col   = job_r.col;
          od_nxt.out_row   = job_r.row;
          state_nxt        = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |=> !ov_r) else $error("result strobe held longer than one cycle");
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(we && re)) else $error("store write during a tap read");
  a_quot_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_QDIV) |-> (!p1_r && !p2_r && !p3_r))
    else $error("quotient started with taps in flight");
endmodule

/* sv/lanczos3_image_upscaler.sv */
// lanczos3_image_upscaler: top level, config registers, front, job queue, back
// depends on lz3_pkg, lz3_front, lz3_fifo, lz3_back
// load transfer: one per cycle unless the queue is full; stored when the idle back pops it
// compute transfer: front busy while the 39-step serial position dividers run and until the job
// is queued; back reads 25 taps, drains its pipeline, then divides out the 8-bit result serially
// reset: config to 640x480 -> 1280x960, queue and controls cleared, store not cleared
// the result strobe lasts one cycle and cannot be held off
module lanczos3_image_upscaler #(
  parameter int MAX_SRC_WIDTH  = lz3_pkg::MAX_SRC_WIDTH_DEF,
  parameter int MAX_SRC_HEIGHT = lz3_pkg::MAX_SRC_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lz3_pkg::in_item_t  in_data,
  output logic               out_valid,
  output lz3_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data
);
  import lz3_pkg::*;

  logic [10:0] src_w_r;
  logic [9:0]  src_h_r;
  logic [12:0] dst_w_r;
  logic [11:0] dst_h_r;
  logic [10:0] sw;
  logic [9:0]  sh;
  logic        push, pop, full, not_empty;
  job_t        push_data, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= 11'd640;
      src_h_r <= 10'd480;
      dst_w_r <= 13'd1280;
      dst_h_r <= 12'd960;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SRC_W: src_w_r <= cfg_data[10:0];
        CFG_SRC_H: src_h_r <= cfg_data[9:0];
        CFG_DST_W: dst_w_r <= cfg_data;
        CFG_DST_H: dst_h_r <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // clamp source size to the store
  assign sw = (32'(src_w_r) > 32'(MAX_SRC_WIDTH))  ? 11'(MAX_SRC_WIDTH)  : src_w_r;
  assign sh = (32'(src_h_r) > 32'(MAX_SRC_HEIGHT)) ? 10'(MAX_SRC_HEIGHT) : src_h_r;

  lz3_front u_front (
    .clk, .rst_n, .start, .busy, .in_data, .sw, .sh,
    .dst_w(dst_w_r), .dst_h(dst_h_r), .push, .push_data, .full
  );

  lz3_fifo u_fifo (
    .clk, .rst_n, .push, .push_data, .pop, .head, .full, .not_empty
  );

  lz3_back #(.MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT)) u_back (
    .clk, .rst_n, .job(head), .job_valid(not_empty), .job_pop(pop),
    .sw, .sh, .out_valid, .out_data
  );
endmodule
